// ===== hw/rtl/bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types, constants and reply tables of the ballast command responder.
// ----------------------------------------------------------------------------
package bcr_pkg;

    // command bytes
    localparam logic [7:0] BYTE_TOGGLE   = 8'h75;
    localparam logic [7:0] BYTE_PAIR_LO  = 8'h00;
    localparam logic [7:0] BYTE_PAIR_HI  = 8'h01;
    localparam logic [7:0] BYTE_PREV_65  = 8'h65;
    localparam logic [7:0] BYTE_PREV_71  = 8'h71;

    // delay limit and reset value of the start delay
    localparam logic [7:0] DELAY_MAX     = 8'd254;
    localparam logic [7:0] DELAY_RESET   = 8'd56;

    // item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // reply sequence codes
    typedef enum logic [3:0] {
        RPL_26, RPL_69, RPL_70, RPL_F0, RPL_F1, RPL_F2, RPL_F3,
        RPL_F4, RPL_F5, RPL_F6, RPL_FA, RPL_FB, RPL_PAIR65, RPL_PAIR71
    } t_reply;

    // one queue write from front to back
    typedef struct packed {
        logic   vld;
        t_reply code;
    } t_reply_wr;

    // number of bytes in a reply sequence
    function automatic logic [1:0] reply_len(input t_reply code);
        logic [1:0] len;
        case (code)
            RPL_26, RPL_70:       len = 2'd1;
            RPL_F1, RPL_PAIR65:   len = 2'd3;
            default:              len = 2'd2;
        endcase
        return len;
    endfunction

    // one byte of a reply sequence
    function automatic logic [7:0] reply_byte(input t_reply code, input logic [1:0] idx);
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        first  = 8'h00;
        second = 8'h00;
        third  = 8'h00;
        case (code)
            RPL_26:     first = 8'h26;
            RPL_69:     begin first = 8'h69; second = 8'h80; end
            RPL_70:     first = 8'h70;
            RPL_F0:     begin first = 8'hF0; second = 8'h01; end
            RPL_F1:     begin first = 8'hF1; second = 8'h2D; third = 8'h22; end
            RPL_F2:     begin first = 8'hF2; second = 8'hBF; end
            RPL_F3:     begin first = 8'hF3; second = 8'h00; end
            RPL_F4:     begin first = 8'hF4; second = 8'h80; end
            RPL_F5:     begin first = 8'hF5; second = 8'h01; end
            RPL_F6:     begin first = 8'hF6; second = 8'h05; end
            RPL_FA:     begin first = 8'hFA; second = 8'h62; end
            RPL_FB:     begin first = 8'hFB; second = 8'h80; end
            RPL_PAIR65: begin first = 8'h65; second = 8'h00; third = 8'h01; end
            RPL_PAIR71: begin first = 8'h71; second = 8'h01; end
            default:    first = 8'h00;
        endcase
        case (idx)
            2'd0:    return first;
            2'd1:    return second;
            default: return third;
        endcase
    endfunction

endpackage

// ===== hw/rtl/bcr_front.sv =====
// ----------------------------------------------------------------------------
// bcr_front
// Accepts words, keeps emulation and delay state, and queues reply codes.
// ----------------------------------------------------------------------------
module bcr_front import bcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_start_delay,
    output t_reply_wr  o_wr
);

    logic       r_emulating, n_emulating;
    logic       r_tx_enabled, n_tx_enabled;
    logic       r_delay_running, n_delay_running;
    logic [7:0] r_delay_count, n_delay_count;
    logic [7:0] r_prev_byte, n_prev_byte;

    logic [7:0] lim;
    logic       hit;
    t_reply     code;

    // clamp the start delay
    assign lim = (i_start_delay > DELAY_MAX) ? DELAY_MAX : i_start_delay;

    // table lookup of the received byte
    always_comb begin
        hit  = 1'b1;
        code = RPL_26;
        case (i_rx_byte)
            8'h26:   code = RPL_26;
            8'h69:   code = RPL_69;
            8'h70:   code = RPL_70;
            8'hF0:   code = RPL_F0;
            8'hF1:   code = RPL_F1;
            8'hF2:   code = RPL_F2;
            8'hF3:   code = RPL_F3;
            8'hF4:   code = RPL_F4;
            8'hF5:   code = RPL_F5;
            8'hF6:   code = RPL_F6;
            8'hFA:   code = RPL_FA;
            8'hFB:   code = RPL_FB;
            default: hit  = 1'b0;
        endcase
    end

    // state update and reply decision for one word
    always_comb begin
        n_emulating     = r_emulating;
        n_tx_enabled    = r_tx_enabled;
        n_delay_running = r_delay_running;
        n_delay_count   = r_delay_count;
        n_prev_byte     = r_prev_byte;
        o_wr.vld        = 1'b0;
        o_wr.code       = code;
        if (i_accept) begin
            if (i_func == FUNC_TICK) begin
                // delay tick
                if (r_delay_running) begin
                    if (r_delay_count <= lim) begin
                        if (r_delay_count == lim) begin
                            n_tx_enabled = 1'b1;
                        end
                        n_delay_count = r_delay_count + 8'd1;
                    end else begin
                        n_delay_count   = 8'd0;
                        n_delay_running = 1'b0;
                    end
                end
            end else if (hit) begin
                o_wr.vld = r_tx_enabled;
            end else if (i_rx_byte == BYTE_TOGGLE) begin
                n_emulating = !r_emulating;
                if (!r_emulating) begin
                    n_delay_running = 1'b1;
                end else begin
                    n_tx_enabled = 1'b0;
                end
            end else if (i_rx_byte == BYTE_PAIR_LO) begin
                o_wr.vld  = r_tx_enabled && (r_prev_byte == BYTE_PREV_65);
                o_wr.code = RPL_PAIR65;
            end else if (i_rx_byte == BYTE_PAIR_HI) begin
                o_wr.vld  = r_tx_enabled && (r_prev_byte == BYTE_PREV_71);
                o_wr.code = RPL_PAIR71;
            end else begin
                n_prev_byte = i_rx_byte;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emulating     <= 1'b0;
            r_tx_enabled    <= 1'b0;
            r_delay_running <= 1'b0;
            r_delay_count   <= 8'd0;
            r_prev_byte     <= 8'd0;
        end else begin
            r_emulating     <= n_emulating;
            r_tx_enabled    <= n_tx_enabled;
            r_delay_running <= n_delay_running;
            r_delay_count   <= n_delay_count;
            r_prev_byte     <= n_prev_byte;
        end
    end

endmodule

// ===== hw/rtl/bcr_queue.sv =====
// ----------------------------------------------------------------------------
// bcr_queue
// Short queue of reply codes between front and back.
// ----------------------------------------------------------------------------
module bcr_queue import bcr_pkg::*; #(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_reply_wr i_wr,
    input  logic      i_rd,
    output logic      o_full,
    output logic      o_vld,
    output t_reply    o_code
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_reply                r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr_ptr;
    logic [DEPTH_LOG2-1:0] r_rd_ptr;
    logic [DEPTH_LOG2:0]   r_count;

    logic do_wr;
    logic do_rd;

    assign o_full = (r_count == (DEPTH_LOG2+1)'(DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_code = r_mem[r_rd_ptr];
    assign do_wr  = i_wr.vld && !o_full;
    assign do_rd  = i_rd && o_vld;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.code;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + DEPTH_LOG2'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + DEPTH_LOG2'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + (DEPTH_LOG2+1)'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - (DEPTH_LOG2+1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/bcr_back.sv =====
// ----------------------------------------------------------------------------
// bcr_back
// Expands reply codes into bytes, one per cycle unless the output register is stalled by pop, into an output register.
// ----------------------------------------------------------------------------
module bcr_back import bcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_vld,
    input  t_reply     i_q_code,
    output logic       o_q_rd,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);

    logic       r_busy;
    t_reply     r_code;
    logic [1:0] r_idx;
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic out_free;
    logic emit;
    logic is_last;

    assign out_free = !r_out_vld || i_pop;
    assign emit     = r_busy && out_free;
    assign is_last  = (r_idx == reply_len(r_code) - 2'd1);
    // take the next code when idle or when the current one finishes
    assign o_q_rd   = !r_busy || (emit && is_last);

    // sequencer over the bytes of one reply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_q_rd) begin
            r_busy <= i_q_vld;
            r_idx  <= 2'd0;
        end else if (emit) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd && i_q_vld) begin
            r_code <= i_q_code;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= reply_byte(r_code, r_idx);
            r_out_last <= is_last;
        end
    end

    assign o_empty   = !r_out_vld;
    assign o_tx_byte = r_out_byte;
    assign o_last    = r_out_last;

endmodule

// ===== hw/rtl/ballast_command_responder_top.sv =====
// ----------------------------------------------------------------------------
// ballast_command_responder_top
// Answers serial command bytes with fixed reply sequences, with emulation
// toggle and a tick-based transmitter start delay.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------
//  input    | push / full       | i_func, i_rx_byte
//  result   | pop / empty       | o_tx_byte, o_last
//  config   | i_cfg_we          | i_cfg_wdata (start delay ticks)
//
//  While full is low the front takes one word per cycle and updates
//  its state in that cycle. The back sends one reply byte per cycle
//  unless pop stalls it, so sustained rate is set by reply length (1 to 3).
//  full rises when the code queue between front and back is full.
//  Reset clears the control state; the start delay returns to 56.
// ----------------------------------------------------------------------------
module ballast_command_responder_top import bcr_pkg::*; #(
    parameter int QUEUE_DEPTH_LOG2 = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0] r_start_delay;
    t_reply_wr  wr;
    logic       q_rd;
    logic       q_vld;
    t_reply     q_code;
    logic       accept;

    assign accept = push && !full;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_start_delay <= i_cfg_wdata;
        end
    end

    bcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_rx_byte     (i_rx_byte),
        .i_start_delay (r_start_delay),
        .o_wr          (wr)
    );

    bcr_queue #(
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd    (q_rd),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_code  (q_code)
    );

    bcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (q_vld),
        .i_q_code  (q_code),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_tx_byte (o_tx_byte),
        .o_last    (o_last)
    );

endmodule
